>>> hw/rtl/rpip_pkg.sv
// Shared types, constants and sizes for the rectilinear point-in-polygon block.
`default_nettype none

package rpip_pkg;

  // Polygon capacity and derived widths
  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int CMD_W        = 2;
  localparam int EDGE_W       = 4;
  localparam int EXT_W        = IDX_W + EDGE_W;

  // Command codes carried on the input beat
  typedef logic [CMD_W-1:0] cmd_t;
  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_QUERY  = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FIRST,
    ST_WALK,
    ST_CLOSE,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start_vtx;   // store vertex 0, restart the list
    logic append_vtx;  // store vertex at the end of the list
    logic q_init;      // capture query point, clear the side flags
    logic fetch;       // advance the read pointer
    logic first;       // latch vertex 0 as first and previous vertex
    logic walk;        // test the edge from previous to fetched vertex
    logic close;       // test the closing edge back to vertex 0
    logic load_out;    // load the result register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;       // no vertex stored
    logic single;      // exactly one vertex stored
    logic last_walk;   // the edge under test ends at the last stored vertex
    logic hit;         // the point lies on the edge under test
    logic out_free;    // the result register can take a new beat
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpip_ctrl.sv
// Controller state machine: sequences vertex stores and the edge walk of a query.
`default_nettype none

module rpip_ctrl
  import rpip_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire cmd_t     in_cmd,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_QUERY)) begin
          state_nxt = stat.empty ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_FIRST;
      ST_FIRST: state_nxt = stat.single ? ST_CLOSE : ST_WALK;
      ST_WALK: begin
        if (stat.hit) begin
          state_nxt = ST_DONE;
        end else if (stat.last_walk) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.start_vtx  = in_acc && (in_cmd == CMD_START);
        cmd.append_vtx = in_acc && (in_cmd == CMD_APPEND);
        cmd.q_init     = in_acc && (in_cmd == CMD_QUERY);
      end
      ST_FETCH: cmd.fetch = 1'b1;
      ST_FIRST: begin
        cmd.fetch = 1'b1;
        cmd.first = 1'b1;
      end
      ST_WALK: begin
        cmd.fetch = 1'b1;
        cmd.walk  = 1'b1;
      end
      ST_CLOSE: cmd.close    = 1'b1;
      ST_DONE:  cmd.load_out = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/rpip_dpath.sv
// Datapath: vertex memory, edge tester, side flags and result register.
`default_nettype none

module rpip_dpath
  import rpip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dp_cmd_t                   cmd,
  output dp_stat_t                       stat,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_is_inside,
  output logic                           out_on_boundary,
  output logic [EDGE_W-1:0]              out_edge_found,
  output logic                           out_overflowed
);

  // Vertex memory, one write and one registered read per cycle
  logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;
  logic        [IDX_W-1:0]   rd_ptr_r;
  logic                      wr_en;
  logic        [IDX_W-1:0]   wr_addr;

  // List bookkeeping
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             has_room;

  // Query walk registers
  logic signed [COORD_W-1:0] px_r, py_r;
  logic signed [COORD_W-1:0] first_x_r, first_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic        [IDX_W-1:0]   edge_r;
  logic                      left_r, right_r, down_r, up_r;
  logic                      hit_r;
  logic        [IDX_W-1:0]   hit_idx_r;

  // Edge tester signals
  logic signed [COORD_W-1:0] bx, by;
  logic signed [COORD_W-1:0] line, across, a_al, b_al, along;
  logic                      vert, spans, on_line, lt, gt, eval, hit;

  // Result register
  logic                      out_valid_r;
  logic                      out_is_inside_r, out_on_boundary_r, out_overflowed_r;
  logic        [EDGE_W-1:0]  out_edge_found_r;
  logic        [EXT_W-1:0]   hit_idx_ext;

  assign has_room = (count_r < CNT_W'(MAX_VERTICES));
  assign wr_en    = cmd.start_vtx || (cmd.append_vtx && has_room);
  assign wr_addr  = cmd.start_vtx ? '0 : count_r[IDX_W-1:0];

  // Store a vertex
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= in_coord_x;
      mem_y[wr_addr] <= in_coord_y;
    end
  end

  // Read the vertex at the walk pointer
  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_ptr_r];
    rd_y_r <= mem_y[rd_ptr_r];
  end

  // Track vertex count and the sticky overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.start_vtx) begin
      count_r <= CNT_W'(1);
      ovf_r   <= 1'b0;
    end else if (cmd.append_vtx) begin
      if (has_room) begin
        count_r <= count_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Test one edge: previous vertex to fetched vertex, or back to vertex 0
  assign bx      = cmd.close ? first_x_r : rd_x_r;
  assign by      = cmd.close ? first_y_r : rd_y_r;
  assign vert    = (prev_x_r == bx);
  assign line    = vert ? prev_x_r : prev_y_r;
  assign across  = vert ? px_r : py_r;
  assign along   = vert ? py_r : px_r;
  assign a_al    = vert ? prev_y_r : prev_x_r;
  assign b_al    = vert ? by : bx;
  assign spans   = ((a_al <= along) && (along <= b_al)) ||
                   ((b_al <= along) && (along <= a_al));
  assign on_line = (across == line);
  assign lt      = (line < across);
  assign gt      = (line > across);
  assign eval    = cmd.walk || cmd.close;
  assign hit     = eval && spans && on_line;

  // Advance the walk and gather side flags
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      px_r     <= in_coord_x;
      py_r     <= in_coord_y;
      rd_ptr_r <= '0;
      edge_r   <= '0;
      left_r   <= 1'b0;
      right_r  <= 1'b0;
      down_r   <= 1'b0;
      up_r     <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (cmd.fetch) begin
        rd_ptr_r <= rd_ptr_r + IDX_W'(1);
      end
      if (cmd.first) begin
        first_x_r <= rd_x_r;
        first_y_r <= rd_y_r;
        prev_x_r  <= rd_x_r;
        prev_y_r  <= rd_y_r;
      end
      if (cmd.walk) begin
        prev_x_r <= rd_x_r;
        prev_y_r <= rd_y_r;
        edge_r   <= edge_r + IDX_W'(1);
      end
      if (hit) begin
        hit_r     <= 1'b1;
        hit_idx_r <= edge_r;
      end else if (eval && spans) begin
        left_r  <= left_r  || ( vert && lt);
        right_r <= right_r || ( vert && gt);
        down_r  <= down_r  || (!vert && lt);
        up_r    <= up_r    || (!vert && gt);
      end
    end
  end

  // Hold the result beat until it is taken
  assign hit_idx_ext = EXT_W'(hit_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_is_inside_r   <= !hit_r && left_r && right_r && down_r && up_r;
      out_on_boundary_r <= hit_r;
      out_edge_found_r  <= hit_r ? hit_idx_ext[EDGE_W-1:0] : '0;
      out_overflowed_r  <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_inside   = out_is_inside_r;
  assign out_on_boundary = out_on_boundary_r;
  assign out_edge_found  = out_edge_found_r;
  assign out_overflowed  = out_overflowed_r;

  // Status to the controller
  assign stat.empty     = (count_r == '0);
  assign stat.single    = (count_r == CNT_W'(1));
  assign stat.last_walk = ((CNT_W'(edge_r) + CNT_W'(2)) == count_r);
  assign stat.hit       = hit;
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (count_r == CNT_W'(MAX_VERTICES)))
    else $error("overflow flagged with room left");

  a_inside_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_is_inside_r && out_on_boundary_r))
    else $error("result both inside and on boundary");

  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_on_boundary_r) |-> (out_edge_found_r == '0))
    else $error("edge index set off the boundary");

endmodule

`default_nettype wire

>>> hw/rtl/rectilinear_point_in_polygon_top.sv
// Top level of the rectilinear point-in-polygon classifier.
// Holds one polygon of up to MAX_VERTICES vertices (16) and classifies query
// points against it. A start or append beat gives no result. A query beat
// keeps the input stalled until its result is loaded, also when the polygon
// is empty, in which case no edge is walked. The walk ends sooner when the
// point lies on an edge, and lasts longer while an earlier result still waits
// unclaimed. The walk length is set by the single read port of the vertex
// memory, which yields one edge a cycle. A finished result waits in an output
// register, so store beats are still taken while it is unclaimed. Beats with
// command code 3 are consumed and dropped. No clearing pass follows reset.
`default_nettype none

module rectilinear_point_in_polygon_top
  import rpip_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [CMD_W-1:0]          in_cmd,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_is_inside,
  output logic                           out_on_boundary,
  output logic [EDGE_W-1:0]              out_edge_found,
  output logic                           out_overflowed
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequence commands
  rpip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Store vertices and walk edges
  rpip_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_inside   (out_is_inside),
    .out_on_boundary (out_on_boundary),
    .out_edge_found  (out_edge_found),
    .out_overflowed  (out_overflowed)
  );

endmodule

`default_nettype wire

>>> verif/rectilinear_point_in_polygon_top_tb.sv
// Self-checking testbench for the rectilinear point-in-polygon classifier.
`default_nettype none

module rectilinear_point_in_polygon_top_tb;
  import rpip_pkg::*;

  localparam cmd_t                       CMD_UNUSED   = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX    = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN    = 32'sh8000_0000;
  localparam int                         TARGET_BEATS = 740;
  localparam int                         DRAIN_EVERY  = 250;
  localparam int                         QUIET_LIMIT  = 5000;
  localparam int                         TAIL_CYCLES  = 30;

  typedef struct packed {
    logic              is_inside;
    logic              on_boundary;
    logic [EDGE_W-1:0] edge_idx;
    logic              overflowed;
  } verdict_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // Shadow polygon, point classifier and queue of verdicts still owed
  class polygon_scoreboard;
    logic signed [COORD_W-1:0] vx [MAX_VERTICES];
    logic signed [COORD_W-1:0] vy [MAX_VERTICES];
    int       nverts;
    bit       ovf;
    verdict_t verdict_q [$];
    int       errors;

    function new();
      nverts = 0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function verdict_t classify_point(logic signed [COORD_W-1:0] px,
                                      logic signed [COORD_W-1:0] py);
      verdict_t                  v;
      logic signed [COORD_W-1:0] ax, ay, bx, by, line, lo, hi, across, along;
      bit                        vert, spans, found, left, right, down, up;
      int                        j;
      v = '0;
      v.overflowed = ovf;
      found = 1'b0;
      left  = 1'b0;
      right = 1'b0;
      down  = 1'b0;
      up    = 1'b0;
      // Walk edges in order; stop at the first one holding the point
      for (int i = 0; i < nverts && !found; i++) begin
        j  = (i + 1 < nverts) ? i + 1 : 0;
        ax = vx[i];
        ay = vy[i];
        bx = vx[j];
        by = vy[j];
        vert   = (ax == bx);
        line   = vert ? ax : ay;
        lo     = vert ? ((ay < by) ? ay : by) : ((ax < bx) ? ax : bx);
        hi     = vert ? ((ay > by) ? ay : by) : ((ax > bx) ? ax : bx);
        across = vert ? px : py;
        along  = vert ? py : px;
        spans  = (lo <= along) && (along <= hi);
        if (spans && across == line) begin
          v.on_boundary = 1'b1;
          v.edge_idx    = EDGE_W'(i);
          found         = 1'b1;
        end else if (spans) begin
          if (vert) begin
            if (line < px) left = 1'b1;
            if (line > px) right = 1'b1;
          end else begin
            if (line < py) down = 1'b1;
            if (line > py) up = 1'b1;
          end
        end
      end
      if (!found) v.is_inside = left && right && down && up;
      return v;
    endfunction

    // Update the shadow polygon with an accepted beat; queries owe a verdict
    function void note_beat(cmd_t c, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
      case (c)
        CMD_START: begin
          vx[0]  = x;
          vy[0]  = y;
          nverts = 1;
          ovf    = 1'b0;
        end
        CMD_APPEND: begin
          if (nverts < MAX_VERTICES) begin
            vx[nverts] = x;
            vy[nverts] = y;
            nverts++;
          end else begin
            ovf = 1'b1;
          end
        end
        CMD_QUERY: verdict_q = {verdict_q, classify_point(x, y)};
        default: ;
      endcase
    endfunction

    // Compare a result beat with the oldest owed verdict
    function void check_result(verdict_t got);
      verdict_t exp;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected result inside=%0d boundary=%0d edge=%0d ovf=%0d",
                   got.is_inside, got.on_boundary, got.edge_idx, got.overflowed);
        return;
      end
      exp = verdict_q.pop_front();
      if (got.is_inside !== exp.is_inside || got.on_boundary !== exp.on_boundary ||
          got.edge_idx !== exp.edge_idx || got.overflowed !== exp.overflowed) begin
        errors++;
        if (errors <= 10)
          $display("tb: mismatch exp inside=%0d boundary=%0d edge=%0d ovf=%0d, %s",
                   exp.is_inside, exp.on_boundary, exp.edge_idx, exp.overflowed,
                   $sformatf("got inside=%0d boundary=%0d edge=%0d ovf=%0d",
                             got.is_inside, got.on_boundary, got.edge_idx,
                             got.overflowed));
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  cmd_t                      in_cmd = CMD_START;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_is_inside;
  logic                      out_on_boundary;
  logic [EDGE_W-1:0]         out_edge_found;
  logic                      out_overflowed;

  polygon_scoreboard sb;
  int                beats_sent = 0;
  int                burst_left = 0;
  stall_mode_t       stall_mode = STALL_NONE;
  int                stall_left = 0;

  rectilinear_point_in_polygon_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_inside   (out_is_inside),
    .out_on_boundary (out_on_boundary),
    .out_edge_found  (out_edge_found),
    .out_overflowed  (out_overflowed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Observe both channels on pre-edge values
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_beat(in_cmd, in_coord_x, in_coord_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_is_inside, out_on_boundary, out_edge_found, out_overflowed});
  end

  // Receiver back-pressure: switch between stall patterns every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  // End the run if neither channel moves a beat for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] base,
                                                       int spread);
    return base + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
  endfunction

  // Sender bursts: between bursts, drop valid for a random gap
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 30) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Present one beat and hold it until the block takes it
  task automatic send_beat(cmd_t c, logic signed [COORD_W-1:0] x,
                           logic signed [COORD_W-1:0] y);
    pace();
    in_valid   <= 1'b1;
    in_cmd     <= c;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    beats_sent++;
  endtask

  // Hold off the sender until every owed verdict has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Corner cases: empty list, append before start, ignored code, full list
  task automatic run_directed();
    send_beat(CMD_QUERY, 32'sd0, 32'sd0);
    send_beat(CMD_APPEND, 32'sd5, 32'sd5);
    send_beat(CMD_QUERY, 32'sd5, 32'sd5);
    send_beat(CMD_QUERY, 32'sd5, 32'sd6);
    send_beat(CMD_UNUSED, COORD_MAX, COORD_MIN);
    // Full-range box with a zero-length edge, a slanted edge and padding
    send_beat(CMD_START, COORD_MIN, COORD_MIN);
    send_beat(CMD_APPEND, COORD_MAX, COORD_MIN);
    send_beat(CMD_APPEND, COORD_MAX, COORD_MAX);
    send_beat(CMD_APPEND, COORD_MAX, COORD_MAX);
    send_beat(CMD_APPEND, 32'sd0, COORD_MAX);
    repeat (MAX_VERTICES - 5) send_beat(CMD_APPEND, COORD_MIN, 32'sd0);
    // One past capacity: drop it and raise the sticky flag
    send_beat(CMD_APPEND, 32'sd1, 32'sd1);
    send_beat(CMD_QUERY, COORD_MIN, -32'sd5);
    send_beat(CMD_QUERY, 32'sd0, 32'sd0);
    send_beat(CMD_QUERY, 32'sd0, COORD_MAX);
  endtask

  // Mostly closed rectilinear polygons with small spans, then nearby queries
  task automatic send_rect_polygon();
    int                        n, m, nq, k;
    logic signed [COORD_W-1:0] bx, by, cx, cy;
    logic signed [COORD_W-1:0] pvx [MAX_VERTICES];
    logic signed [COORD_W-1:0] pvy [MAX_VERTICES];
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4);
      1:       n = $urandom_range(1, 3);
      default: n = 2 * $urandom_range(2, MAX_VERTICES / 2);
    endcase
    m = (n > MAX_VERTICES) ? MAX_VERTICES : n;
    case ($urandom_range(0, 3))
      0: begin
        bx = '0;
        by = '0;
      end
      1: begin
        bx = COORD_MAX - 32'sd4;
        by = COORD_MIN + 32'sd4;
      end
      2: begin
        bx = COORD_MIN + 32'sd4;
        by = COORD_MAX - 32'sd4;
      end
      default: begin
        bx = $urandom;
        by = $urandom;
      end
    endcase
    cx = jitter(bx, 8);
    cy = jitter(by, 8);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        send_beat(CMD_START, cx, cy);
      end else begin
        // Alternate x and y steps; close the last edge back onto vertex 0
        if (i == m - 1 && m % 2 == 0 && m >= 4) cx = pvx[0];
        else if (i % 2) cx = jitter(bx, 8);
        else cy = jitter(by, 8);
        send_beat(CMD_APPEND, cx, cy);
        if ($urandom_range(0, 7) == 0) send_beat(CMD_QUERY, jitter(bx, 10), jitter(by, 10));
      end
      if (i < MAX_VERTICES) begin
        pvx[i] = cx;
        pvy[i] = cy;
      end
    end
    nq = $urandom_range(2, 8);
    repeat (nq) begin
      k = $urandom_range(0, m - 1);
      case ($urandom_range(0, 5))
        0:       send_beat(CMD_QUERY, pvx[k], pvy[k]);
        1:       send_beat(CMD_QUERY, pvx[k], jitter(by, 10));
        2:       send_beat(CMD_QUERY, jitter(bx, 10), pvy[k]);
        3:       send_beat(CMD_UNUSED, jitter(bx, 10), jitter(by, 10));
        default: send_beat(CMD_QUERY, jitter(bx, 10), jitter(by, 10));
      endcase
    end
  endtask

  // Any command with full-range coordinates
  task automatic send_noise();
    int nb;
    nb = $urandom_range(3, 12);
    repeat (nb) send_beat(cmd_t'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  initial begin
    int next_drain;
    sb = new();
    next_drain = DRAIN_EVERY;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (beats_sent < TARGET_BEATS) begin
      if (beats_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      if ($urandom_range(0, 9) < 7) send_rect_polygon();
      else send_noise();
    end
    // Stop sending, wait for the owed verdicts, then let the block settle
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/rpip_pkg.sv
hw/rtl/rpip_ctrl.sv
hw/rtl/rpip_dpath.sv
hw/rtl/rectilinear_point_in_polygon_top.sv
verif/rectilinear_point_in_polygon_top_tb.sv
